>>> hdl/bitmap_page_transposer_assert.svh
// Assertion macros shared by the bitmap page transposer RTL.
// Expects signals named clk and rst_n in the including module's scope.
`ifndef BITMAP_PAGE_TRANSPOSER_ASSERT_SVH
`define BITMAP_PAGE_TRANSPOSER_ASSERT_SVH
`ifndef SYNTHESIS
`define BPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) else $error(msg);
`else
`define BPT_ASSERT(lbl, prop, msg)
`define BPT_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

>>> hdl/bpt_pkg.sv
// Package for the bitmap page transposer: codes, state type, geometry constants.
// No dependencies.
`timescale 1ns / 1ps

package bpt_pkg;

  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 32;

  localparam int PIX_PER_WORD   = 16;
  localparam int ROWS_PER_PAGE  = 8;
  localparam int BYTES_PER_READ = 4;

  localparam int WORD_IDX_W = 8;
  localparam int WORD_W     = 16;
  localparam int READ_IDX_W = 9;
  localparam int RDATA_W    = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } bpt_op_t;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_INVERT = 1'b0,
    REG_PACK32 = 1'b1
  } bpt_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_GATHER,
    ST_DRAIN,
    ST_HOLD
  } bpt_state_t;

endpackage

>>> hdl/bpt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/bitmap_page_transposer.sv
// Top level of the bitmap page transposer: frame store, page gather sequencer, APB registers.
// Depends on bpt_pkg, bpt_ram and bitmap_page_transposer_assert.svh.
//
//  channel | direction | content
//  --------+-----------+--------------------------------------------------------------
//  in_*    | slave     | tuser = opcode; tdata = word_index, word_data, read_index
//  out_*   | master    | tdata = read_data (one transaction per read, none per write)
//  cfg_*   | APB slave | 0x0 invert, 0x4 pack32; pready tied high
//
// A write transaction is taken without a stall (in_tready stays high).
// After a read is accepted in_tready is low in SETUP1, SETUP2, GATHER (one row per cycle,
// 8 rows per byte, B = 1 byte or 4 in pack32), DRAIN and HOLD; the RAM has one read port.
// SETUP1 and SETUP2 split the byte index into page and column (reciprocal multiply).
// A finished result waits in out_tdata while writes are taken; a further read is gathered
// but then waits in HOLD until the previous result has left the output register.
// Reset (synchronous, rst_n low) clears control and APB registers; datapath and RAM are not.
`timescale 1ns / 1ps
`include "bitmap_page_transposer_assert.svh"

module bitmap_page_transposer #(
  parameter int FRAME_WIDTH  = bpt_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = bpt_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [39:0]                     in_tdata,  // word_index[7:0], word_data[23:8],
                                                     // read_index[32:24], zero pad
  input  logic [0:0]                      in_tuser,  // opcode
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bpt_pkg::RDATA_W-1:0]     out_tdata, // read_data[31:0]
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bpt_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [bpt_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [bpt_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  // Frame geometry
  localparam int STORE_DEPTH = (FRAME_WIDTH * FRAME_HEIGHT + bpt_pkg::PIX_PER_WORD - 1)
                               / bpt_pkg::PIX_PER_WORD;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int PAGE_COUNT  = (FRAME_HEIGHT + bpt_pkg::ROWS_PER_PAGE - 1)
                               / bpt_pkg::ROWS_PER_PAGE;
  localparam int K_W         = $clog2(bpt_pkg::ROWS_PER_PAGE);
  localparam int B_W         = $clog2(bpt_pkg::BYTES_PER_READ);
  localparam int STEP_W      = K_W + B_W;
  localparam int NW          = bpt_pkg::READ_IDX_W + B_W;      // byte index width
  localparam int PG_W        = NW;
  localparam int RW          = PG_W + K_W;
  localparam int ROW_W       = $clog2(PAGE_COUNT * bpt_pkg::ROWS_PER_PAGE);
  localparam int COL_W       = $clog2(FRAME_WIDTH);
  localparam int PIX_W       = $clog2(PAGE_COUNT * bpt_pkg::ROWS_PER_PAGE * FRAME_WIDTH);
  localparam int BIT_W       = $clog2(bpt_pkg::PIX_PER_WORD);
  // n / FRAME_WIDTH by reciprocal; estimate is low by at most one for n < 2**NW
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / FRAME_WIDTH;
  localparam int RC_W        = $clog2(RECIP + 1);
  localparam int PROD_W      = NW + RC_W;

  // Input field unpacking
  logic                            in_opcode;
  logic [bpt_pkg::WORD_IDX_W-1:0]  in_word_index;
  logic [bpt_pkg::WORD_W-1:0]      in_word_data;
  logic [bpt_pkg::READ_IDX_W-1:0]  in_read_index;

  assign in_opcode     = in_tuser[0];
  assign in_word_index = in_tdata[7:0];
  assign in_word_data  = in_tdata[23:8];
  assign in_read_index = in_tdata[32:24];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       invert_r, invert_nxt;
  logic       pack32_r, pack32_nxt;
  logic       cfg_wr;
  bpt_pkg::bpt_reg_t cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = bpt_pkg::bpt_reg_t'(cfg_paddr[2]);

  always_comb begin
    invert_nxt = invert_r;
    pack32_nxt = pack32_r;
    if (cfg_wr) begin
      case (cfg_sel)
        bpt_pkg::REG_INVERT: invert_nxt = cfg_pwdata[0];
        bpt_pkg::REG_PACK32: pack32_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      bpt_pkg::REG_INVERT: cfg_prdata = {{(bpt_pkg::CFG_DATA_W-1){1'b0}}, invert_r};
      bpt_pkg::REG_PACK32: cfg_prdata = {{(bpt_pkg::CFG_DATA_W-1){1'b0}}, pack32_r};
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
      pack32_r <= 1'b0;
    end else begin
      invert_r <= invert_nxt;
      pack32_r <= pack32_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  bpt_pkg::bpt_state_t state_r, state_nxt;

  logic              in_acc;
  logic              rd_acc;
  logic              wr_en;
  logic              issue_en;
  logic              load_out;
  logic              out_tvalid_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_last;
  logic              pack_r;

  assign in_acc    = in_tvalid & in_tready;
  assign rd_acc    = in_acc && (bpt_pkg::bpt_op_t'(in_opcode) == bpt_pkg::OP_READ);
  assign step_last = pack_r ? STEP_W'(bpt_pkg::BYTES_PER_READ * bpt_pkg::ROWS_PER_PAGE - 1)
                            : STEP_W'(bpt_pkg::ROWS_PER_PAGE - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpt_pkg::ST_IDLE:   if (rd_acc) state_nxt = bpt_pkg::ST_SETUP1;
      bpt_pkg::ST_SETUP1: state_nxt = bpt_pkg::ST_SETUP2;
      bpt_pkg::ST_SETUP2: state_nxt = bpt_pkg::ST_GATHER;
      bpt_pkg::ST_GATHER: if (step_r == step_last) state_nxt = bpt_pkg::ST_DRAIN;
      bpt_pkg::ST_DRAIN:  state_nxt = bpt_pkg::ST_HOLD;
      bpt_pkg::ST_HOLD:   if (load_out) state_nxt = bpt_pkg::ST_IDLE;
      default:            state_nxt = bpt_pkg::ST_IDLE;
    endcase
  end

  // Writes and reads never overlap in the RAM: reads are only issued in GATHER
  always_comb begin
    in_tready = 1'b0;
    issue_en  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      bpt_pkg::ST_IDLE:   in_tready = 1'b1;
      bpt_pkg::ST_GATHER: issue_en  = 1'b1;
      bpt_pkg::ST_HOLD:   load_out  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Byte index -> page / column split
  // --------------------------------------------------------------------------
  logic [NW-1:0]     n_r;
  logic [PROD_W-1:0] prod_r;
  logic [NW-1:0]     q_est;
  logic [NW-1:0]     rem_full;
  logic [PG_W-1:0]   split_page;
  logic [COL_W-1:0]  split_rem;
  logic [PG_W-1:0]   cur_page_r;
  logic [COL_W-1:0]  cur_rem_r;

  always_comb begin
    q_est    = NW'(prod_r >> RECIP_SHIFT);
    rem_full = n_r - NW'(q_est * NW'(FRAME_WIDTH));
    if (rem_full >= NW'(FRAME_WIDTH)) begin
      split_page = PG_W'(q_est) + PG_W'(1);
      split_rem  = COL_W'(rem_full - NW'(FRAME_WIDTH));
    end else begin
      split_page = PG_W'(q_est);
      split_rem  = COL_W'(rem_full);
    end
  end

  // --------------------------------------------------------------------------
  // Row fetch: one pixel row of the current byte per cycle
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [BIT_W-1:0]  bit_sel;
    logic              use_pix;   // row inside frame and page inside frame
    logic [STEP_W-1:0] pos;       // destination bit in the result word
  } tag_t;

  logic [B_W-1:0]   issue_b;
  logic [K_W-1:0]   issue_k;
  logic [RW-1:0]    issue_row;
  logic [COL_W-1:0] issue_col;
  logic [PIX_W-1:0] issue_pix;
  logic [AW-1:0]    issue_addr;
  tag_t             issue_tag;
  tag_t             tag_r;
  logic             tag_vld_r;
  logic             byte_end;

  assign issue_b  = step_r[STEP_W-1:K_W];
  assign issue_k  = step_r[K_W-1:0];
  assign byte_end = (issue_k == K_W'(bpt_pkg::ROWS_PER_PAGE - 1));

  always_comb begin
    issue_row  = {cur_page_r, issue_k};
    issue_col  = COL_W'(FRAME_WIDTH - 1) - cur_rem_r;
    issue_pix  = PIX_W'(PIX_W'(issue_row[ROW_W-1:0]) * PIX_W'(FRAME_WIDTH))
                 + PIX_W'(issue_col);
    issue_tag.use_pix = (cur_page_r < PG_W'(PAGE_COUNT)) &&
                        (issue_row < RW'(FRAME_HEIGHT));
    issue_tag.bit_sel = issue_pix[BIT_W-1:0];
    // pack32: byte b lands in bits (3-b)*8 + k, first byte most significant
    issue_tag.pos     = pack_r ? {~issue_b, issue_k} : STEP_W'(issue_k);
    issue_addr        = issue_tag.use_pix ? AW'(issue_pix >> BIT_W) : '0;
  end

  // Frame store
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bpt_pkg::WORD_W-1:0] ram_rdata;

  assign wr_en     = in_acc && (bpt_pkg::bpt_op_t'(in_opcode) == bpt_pkg::OP_WRITE);
  assign ram_we    = wr_en && (32'(in_word_index) < STORE_DEPTH);
  assign ram_waddr = AW'(in_word_index);

  bpt_ram #(
    .WIDTH (bpt_pkg::WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_word_data),
    .raddr (issue_addr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  logic [bpt_pkg::RDATA_W-1:0] acc_r;
  logic [bpt_pkg::RDATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      step_r       <= '0;
    end else begin
      tag_vld_r <= issue_en;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (rd_acc) begin
        step_r <= '0;
      end else if (issue_en) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_acc) begin
      n_r    <= pack32_r ? {in_read_index, B_W'(0)} : NW'(in_read_index);
      pack_r <= pack32_r;
    end
    if (state_r == bpt_pkg::ST_SETUP1) begin
      prod_r <= PROD_W'(n_r) * PROD_W'(RECIP);
    end
    if (state_r == bpt_pkg::ST_SETUP2) begin
      cur_page_r <= split_page;
      cur_rem_r  <= split_rem;
    end else if (issue_en && byte_end) begin
      if (cur_rem_r == COL_W'(FRAME_WIDTH - 1)) begin
        cur_rem_r  <= '0;
        cur_page_r <= cur_page_r + PG_W'(1);
      end else begin
        cur_rem_r <= cur_rem_r + COL_W'(1);
      end
    end
    if (issue_en) begin
      tag_r <= issue_tag;
    end
    // Pixel lands in the cycle after its row was fetched; rows outside the frame stay zero
    if (rd_acc) begin
      acc_r <= '0;
    end else if (tag_vld_r) begin
      acc_r[tag_r.pos] <= tag_r.use_pix & (ram_rdata[tag_r.bit_sel] ^ invert_r);
    end
    if (load_out) begin
      out_tdata_r <= acc_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BPT_ASSERT_NEXT(a_read_starts, rd_acc, state_r == bpt_pkg::ST_SETUP1, "read not started")
  `BPT_ASSERT(a_write_idle, ram_we |-> state_r == bpt_pkg::ST_IDLE, "RAM write outside idle")
  `BPT_ASSERT(a_tag_in_gather, tag_vld_r |-> !in_tready && !load_out, "fetch tag outside gather")
  `BPT_ASSERT(a_out_from_hold, $rose(out_tvalid_r) |-> $past(load_out), "result not from hold")

endmodule
